[src/sha1_pkg.sv]
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } t_out_item;

    // Command from the front part to the compression engine.
    typedef struct packed {
        logic [511:0] block;
        logic         last;
    } t_blk_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_eng_state;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

endpackage

[src/sha1_byte_stream_hasher.sv]
// Throughput: one byte transfer per cycle into the block register when not stalled
//   (a block command waiting, or padding); blocks then pass the one-round-per-cycle engine.
// After the end transfer, one or two padding blocks are hashed; the digest is then
//   held on the output until taken.
// Reset (synchronous, active low) restores the SHA-1 initial chaining values and
//   clears the byte count; the block register is not cleared.
module sha1_byte_stream_hasher
    import sha1_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    // Front: byte packing and padding; one-deep command register is the queue.
    logic     w_cmd_valid;
    logic     w_cmd_stall;
    t_blk_cmd w_cmd;

    sha1_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_stall (w_cmd_stall),
        .o_cmd       (w_cmd)
    );

    // Back: compression rounds and the digest transfer.
    sha1_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_stall (w_cmd_stall),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

`ifndef NO_ASSERTIONS
    // A stalled digest stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("digest changed while stalled");
    // The engine never takes a block while a digest waits.
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_cmd_stall)
        else $error("engine accepted a block during digest output");
`endif
endmodule

[src/sha1_front.sv]
module sha1_front
    import sha1_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_stall,
    output t_blk_cmd o_cmd
);
    // Block assembly; padding emits up to two commands after an end.
    logic [511:0] r_blk;      // byte 0 of the block sits in the top bits
    logic [63:0]  r_total;
    logic         r_pad;      // padding in progress
    logic         r_len_blk;  // length-only block still to go
    logic         r_cmd_valid;
    t_blk_cmd     r_cmd;
    logic [511:0] w_pad_blk;
    logic [5:0]   w_pos;
    logic         w_acc;
    logic [63:0]  w_bits;

    assign o_stall     = r_pad || r_cmd_valid;
    assign w_acc       = i_valid && !o_stall;
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;
    assign w_pos       = r_total[5:0];
    assign w_bits      = {r_total[60:0], 3'b000};

    // Current bytes, then the pad byte, then zeros.
    always_comb begin
        for (int i = 0; i < 64; i++) begin
            if (6'(i) < w_pos) begin
                w_pad_blk[511 - 8*i -: 8] = r_blk[511 - 8*i -: 8];
            end else if (6'(i) == w_pos) begin
                w_pad_blk[511 - 8*i -: 8] = PAD_BYTE;
            end else begin
                w_pad_blk[511 - 8*i -: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_pad       <= 1'b0;
            r_len_blk   <= 1'b0;
            r_cmd_valid <= 1'b0;
        end else begin
            if (r_cmd_valid) begin
                if (!i_cmd_stall) begin
                    r_cmd_valid <= 1'b0;
                end
            end else if (w_acc) begin
                if (i_item.byte_valid) begin
                    r_blk[{~w_pos, 3'b000} +: 8] <= i_item.data_byte;
                    r_total <= r_total + 64'd1;
                    if (w_pos == 6'd63) begin
                        // full block goes out before any padding
                        r_cmd_valid <= 1'b1;
                        r_cmd.block <= {r_blk[511:8], i_item.data_byte};
                        r_cmd.last  <= 1'b0;
                    end
                end
                if (i_item.end_of_message) begin
                    r_pad <= 1'b1;
                end
            end else if (r_pad) begin
                r_cmd_valid <= 1'b1;
                if (r_len_blk) begin
                    r_cmd.block <= {448'd0, w_bits};
                    r_cmd.last  <= 1'b1;
                    r_pad       <= 1'b0;
                    r_len_blk   <= 1'b0;
                    r_total     <= '0;
                end else if (w_pos >= LEN_POS) begin
                    // pad byte lands in this block, length goes in the next
                    r_cmd.block <= w_pad_blk;
                    r_cmd.last  <= 1'b0;
                    r_len_blk   <= 1'b1;
                end else begin
                    r_cmd.block <= {w_pad_blk[511:64], w_bits};
                    r_cmd.last  <= 1'b1;
                    r_pad       <= 1'b0;
                    r_total     <= '0;
                end
            end
        end
    end
endmodule

[src/sha1_engine.sv]
module sha1_engine
    import sha1_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_stall,
    input  t_blk_cmd  i_cmd,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    t_eng_state  r_state, n_state;
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [16];
    logic [6:0]  r_t;
    logic        r_last;
    logic [31:0] w_wt, w_wnew, w_f, w_k, w_tmp;
    logic        w_take;

    assign w_take = (r_state == ST_IDLE) && i_cmd_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_cmd_valid) n_state = ST_ROUND;
            ST_ROUND: if (r_t == 7'd79) n_state = ST_ADD;
            ST_ADD:   n_state = r_last ? ST_OUT : ST_IDLE;
            ST_OUT:   if (!i_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_stall = (r_state != ST_IDLE);
        o_valid     = (r_state == ST_OUT);
        o_item      = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
    end

    always_comb begin
        w_wnew = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_wnew = {w_wnew[30:0], w_wnew[31]};
        w_wt   = (r_t < 7'd16) ? r_w[0] : w_wnew;
        if (r_t < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K0;
        end else if (r_t < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_t < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
        w_tmp = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_wt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_h[0] <= H0_INIT; r_h[1] <= H1_INIT; r_h[2] <= H2_INIT;
            r_h[3] <= H3_INIT; r_h[4] <= H4_INIT;
            r_t <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        for (int i = 0; i < 16; i++) begin
                            r_w[i] <= i_cmd.block[511 - 32*i -: 32];
                        end
                        r_last <= i_cmd.last;
                        r_t <= '0;
                        r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                        r_d <= r_h[3]; r_e <= r_h[4];
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_wt;
                    r_e <= r_d; r_d <= r_c;
                    r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a; r_a <= w_tmp;
                    r_t <= r_t + 7'd1;
                end
                ST_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        r_h[0] <= H0_INIT; r_h[1] <= H1_INIT; r_h[2] <= H2_INIT;
                        r_h[3] <= H3_INIT; r_h[4] <= H4_INIT;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
